>>> src/lse_pkg.sv
// Shared types and constants for the line-scan edge steering block.
package lse_pkg;

    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 16;
    localparam int OUT_USER_W  = 2;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int SAMPLE_W    = 12;
    localparam int POS_W       = 7;
    localparam int DUTY_W      = 8;
    localparam int SLOPE_W     = 10;
    localparam int THRESH_W    = 12;
    localparam int PROD_W      = POS_W + SLOPE_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // floor(x / 1000) = (x * RECIP_MULT) >> RECIP_SHIFT for x < 2^PROD_W
    localparam int RECIP_W     = 18;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 18'd134218;
    localparam int RECIP_SHIFT = 27;
    localparam int SCALED_W    = PROD_W + RECIP_W;

    localparam logic [DUTY_W-1:0] DUTY_RESET = 8'd150;
    localparam logic [DUTY_W-1:0] DUTY_MAX   = 8'd255;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DARK_THRESHOLD = 3'd0,
        CFG_SCAN_START     = 3'd1,
        CFG_SCAN_END       = 3'd2,
        CFG_SLOPE_MILLI    = 3'd3,
        CFG_DUTY_OFFSET    = 3'd4,
        CFG_REJECT_BAND    = 3'd5,
        CFG_DEAD_BAND      = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [THRESH_W-1:0] dark_threshold;
        logic [POS_W-1:0]    scan_start;
        logic [POS_W-1:0]    scan_end;
        logic [SLOPE_W-1:0]  slope_milli;
        logic [DUTY_W-1:0]   duty_offset;
        logic [DUTY_W-1:0]   reject_band;
        logic [DUTY_W-1:0]   dead_band;
    } cfg_t;

    // Per-line result handed from the edge search to the duty stage
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } line_rec_t;

endpackage

>>> src/lse_front.sv
// Pixel intake: sliding window, incremental sum difference and first-edge search.
module lse_front #(
    parameter int HALF_WINDOW = 7,
    parameter int LINE_PIXELS = 128,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lse_pkg::cfg_t                 cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lse_pkg::IN_DATA_W-1:0] s_tdata,  // [11:0] sample
    input  logic                          s_tlast,  // line_end
    input  logic                          q_full,
    output logic                          q_push,
    output lse_pkg::line_rec_t            q_rec
);
    import lse_pkg::*;

    localparam int WIN_LEN = 2 * HALF_WINDOW;
    localparam int D_W     = SAMPLE_BITS + $clog2(HALF_WINDOW + 1) + 2;

    logic [SAMPLE_BITS-1:0] win_reg [WIN_LEN];
    logic signed [D_W-1:0]  diff_reg, diff_next;
    logic [7:0]             pos_reg;
    logic                   seen_reg;
    logic [POS_W-1:0]       found_reg;

    logic                   accept;
    logic [15:0]            samp_wide;
    logic [SAMPLE_BITS-1:0] samp;
    logic                   in_line;
    logic [7:0]             p;
    logic                   in_range;
    logic                   dark;
    logic                   hit;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign samp_wide = {4'b0, s_tdata[SAMPLE_W-1:0]};
    assign samp      = samp_wide[SAMPLE_BITS-1:0];

    assign in_line   = {1'b0, pos_reg} < 9'(LINE_PIXELS);
    assign p         = pos_reg - 8'(WIN_LEN - 1);
    assign in_range  = (pos_reg >= 8'(WIN_LEN - 1)) && (p >= {1'b0, cfg.scan_start})
                       && (p <= {1'b0, cfg.scan_end});
    assign dark      = 16'(win_reg[WIN_LEN-2]) < 16'(cfg.dark_threshold);

    // newer half minus older half after the shift
    assign diff_next = diff_reg
                     + $signed({{(D_W-SAMPLE_BITS){1'b0}}, samp})
                     - $signed({{(D_W-SAMPLE_BITS-1){1'b0}}, win_reg[HALF_WINDOW-1], 1'b0})
                     + $signed({{(D_W-SAMPLE_BITS){1'b0}}, win_reg[WIN_LEN-1]});

    assign hit = in_line && !seen_reg && in_range && dark && (diff_next > 0);

    assign q_push    = accept && s_tlast;
    assign q_rec.found = seen_reg || hit;
    assign q_rec.pos   = seen_reg ? found_reg : (hit ? p[POS_W-1:0] : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            found_reg <= '0;
            diff_reg  <= '0;
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                // clear per-line state after the last pixel
                pos_reg   <= '0;
                seen_reg  <= 1'b0;
                found_reg <= '0;
                diff_reg  <= '0;
                for (int i = 0; i < WIN_LEN; i++)
                begin
                    win_reg[i] <= '0;
                end
            end
            else
            begin
                if (pos_reg != 8'd255)
                begin
                    pos_reg <= pos_reg + 8'd1;
                end
                if (in_line)
                begin
                    win_reg[0] <= samp;
                    for (int i = 1; i < WIN_LEN; i++)
                    begin
                        win_reg[i] <= win_reg[i-1];
                    end
                    diff_reg <= diff_next;
                    if (hit)
                    begin
                        seen_reg  <= 1'b1;
                        found_reg <= p[POS_W-1:0];
                    end
                end
            end
        end
    end

    a_found_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> found_reg == '0)
        else $error("found position set without an edge");

    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> pos_reg == '0 && !seen_reg)
        else $error("line state not cleared at line end");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !s_tlast && pos_reg != 8'd255 |=> pos_reg == $past(pos_reg) + 8'd1)
        else $error("pixel position did not advance");

endmodule

>>> src/lse_queue.sv
// Short register queue of per-line results between the edge search and the duty stage.
module lse_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lse_pkg::line_rec_t push_rec,
    input  logic               pop,
    output lse_pkg::line_rec_t pop_rec,
    output logic               full,
    output logic               empty
);
    import lse_pkg::*;

    line_rec_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full    = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign pop_rec = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        push && pop |=> count_reg == $past(count_reg))
        else $error("queue count moved on simultaneous push and pop");

endmodule

>>> src/lse_back.sv
// Duty pipeline: position times gain, divide by 1000, offset, band check, output register.
module lse_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lse_pkg::cfg_t                  cfg,
    input  logic                           q_empty,
    input  lse_pkg::line_rec_t             q_rec,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lse_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] servo_duty, [14:8] edge_position
    output logic [lse_pkg::OUT_USER_W-1:0] m_tuser   // [0] duty_updated, [1] edge_found
);
    import lse_pkg::*;

    logic                 en;

    logic                 v1_reg;
    line_rec_t            rec1_reg;
    logic [PROD_W-1:0]    prod_reg;

    logic                 v2_reg;
    line_rec_t            rec2_reg;
    logic [DUTY_W-1:0]    quot_reg;

    logic                 out_valid_reg;
    logic [DUTY_W-1:0]    out_duty_reg;
    logic                 out_updated_reg;
    line_rec_t            out_rec_reg;
    logic [DUTY_W-1:0]    prev_duty_reg;

    logic [SCALED_W-1:0]  scaled;
    logic [DUTY_W:0]      duty_sum;
    logic [DUTY_W-1:0]    duty;
    logic [DUTY_W-1:0]    diff;
    logic                 take;

    // the whole pipeline holds while a result waits
    assign en    = !out_valid_reg || m_tready;
    assign q_pop = en && !q_empty;

    assign scaled   = SCALED_W'(prod_reg) * SCALED_W'(RECIP_MULT);
    assign duty_sum = {1'b0, quot_reg} + {1'b0, cfg.duty_offset};
    assign duty     = duty_sum[DUTY_W] ? DUTY_MAX : duty_sum[DUTY_W-1:0];
    assign diff     = (duty > prev_duty_reg) ? duty - prev_duty_reg : prev_duty_reg - duty;
    assign take     = (diff <= cfg.reject_band) && (diff > cfg.dead_band);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec1_reg <= q_rec;
            prod_reg <= PROD_W'(q_rec.pos) * PROD_W'(cfg.slope_milli);
            rec2_reg <= rec1_reg;
            quot_reg <= scaled[RECIP_SHIFT +: DUTY_W];
            if (v2_reg)
            begin
                out_rec_reg     <= rec2_reg;
                out_duty_reg    <= take ? duty : prev_duty_reg;
                out_updated_reg <= take;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_duty_reg <= DUTY_RESET;
        end
        else if (en)
        begin
            v1_reg        <= !q_empty;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
            if (v2_reg && take)
            begin
                prev_duty_reg <= duty;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_rec_reg.pos, out_duty_reg};
    assign m_tuser  = {out_rec_reg.found, out_updated_reg};

    a_duty_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_duty_reg == prev_duty_reg)
        else $error("reported duty differs from held duty");

    a_no_edge_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_rec_reg.found |-> out_rec_reg.pos == '0)
        else $error("position reported without an edge");

    a_hold_stages: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> v1_reg == $past(v1_reg) && v2_reg == $past(v2_reg))
        else $error("pipeline moved while stalled");

endmodule

>>> src/line_scan_edge_steering_top.sv
// Top level: configuration registers, pixel front end, line queue and duty pipeline.
//
// Pixels stream in on the s_ stream ports, one item per clock, with tlast on
// the last pixel of each line; s_tready drops only when the four-entry line
// queue is full. The edge search runs in the same cycle as each pixel, using a
// running difference of the two window half sums. One result item leaves per
// line after its last pixel is taken, through the queue and three duty
// stages: multiply by gain, multiply by the reciprocal of 1000, offset and
// band check. Results leave at up to one per clock while m_tready is high,
// set by the single output register. The user must write registers through
// cfg_we/cfg_addr/cfg_wdata only while no line is in flight (not enforced).
module line_scan_edge_steering_top #(
    parameter int HALF_WINDOW = 7,
    parameter int LINE_PIXELS = 128,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lse_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lse_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lse_pkg::IN_DATA_W-1:0]  s_tdata,  // [11:0] sample
    input  logic                           s_tlast,  // line_end
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lse_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] servo_duty, [14:8] edge_position
    output logic [lse_pkg::OUT_USER_W-1:0] m_tuser   // [0] duty_updated, [1] edge_found
);
    import lse_pkg::*;

    cfg_t      cfg_reg;
    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    line_rec_t push_rec;
    line_rec_t pop_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_threshold <= 12'd3500;
            cfg_reg.scan_start     <= 7'd20;
            cfg_reg.scan_end       <= 7'd108;
            cfg_reg.slope_milli    <= 10'd568;
            cfg_reg.duty_offset    <= 8'd118;
            cfg_reg.reject_band    <= 8'd10;
            cfg_reg.dead_band      <= 8'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_DARK_THRESHOLD: cfg_reg.dark_threshold <= cfg_wdata[THRESH_W-1:0];
                CFG_SCAN_START:     cfg_reg.scan_start     <= cfg_wdata[POS_W-1:0];
                CFG_SCAN_END:       cfg_reg.scan_end       <= cfg_wdata[POS_W-1:0];
                CFG_SLOPE_MILLI:    cfg_reg.slope_milli    <= cfg_wdata[SLOPE_W-1:0];
                CFG_DUTY_OFFSET:    cfg_reg.duty_offset    <= cfg_wdata[DUTY_W-1:0];
                CFG_REJECT_BAND:    cfg_reg.reject_band    <= cfg_wdata[DUTY_W-1:0];
                CFG_DEAD_BAND:      cfg_reg.dead_band      <= cfg_wdata[DUTY_W-1:0];
                default:            ;
            endcase
        end
    end

    lse_front #(
        .HALF_WINDOW (HALF_WINDOW),
        .LINE_PIXELS (LINE_PIXELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (push_rec)
    );

    lse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .pop_rec  (pop_rec),
        .full     (q_full),
        .empty    (q_empty)
    );

    lse_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_rec    (pop_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
